/* rtl/clock_with_keypad_time_entry_defines.svh */
// Assertion macros for the keypad clock.
`ifndef CLOCK_WITH_KEYPAD_TIME_ENTRY_DEFINES_SVH
`define CLOCK_WITH_KEYPAD_TIME_ENTRY_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define CLKKEY_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define CLKKEY_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/clkkey_pkg.sv */
// Constants and codes for the keypad clock.
`default_nettype none

package clkkey_pkg;

  // Input operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_KEY  = 1'b1;

  // Key codes (ASCII)
  localparam logic [7:0] KEY_STAR = 8'd42;
  localparam logic [7:0] KEY_ZERO = 8'd48;
  localparam logic [7:0] KEY_NINE = 8'd57;

  // Entry position: which digit the next key fills
  localparam logic [1:0] POS_HOUR_TENS  = 2'd0;
  localparam logic [1:0] POS_HOUR_UNITS = 2'd1;
  localparam logic [1:0] POS_MIN_TENS   = 2'd2;
  localparam logic [1:0] POS_MIN_UNITS  = 2'd3;

  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd1000;

  localparam logic [6:0] SECONDS_WRAP = 7'd60;
  localparam logic [6:0] MINUTES_WRAP = 7'd60;
  localparam logic [6:0] HOURS_WRAP   = 7'd24;
  localparam logic [6:0] HOURS_LAST   = 7'd23;

  // d * 10 for a decimal digit, without a multiplier
  function automatic logic [6:0] times_ten(input logic [3:0] d);
    logic [6:0] x;
    x = {3'd0, d};
    return (x << 3) + (x << 1);
  endfunction

endpackage

`default_nettype wire

/* rtl/clock_with_keypad_time_entry.sv */
// Top level of the keypad clock: time keeping, key entry and result register.
//
// Usage:
//   Input channel (in_valid / in_stall, fields opcode, key_code) carries one
//   item per transfer: opcode OP_TICK is one timer tick, OP_KEY a key press.
//   Output channel (out_valid / out_stall) carries one result per input item:
//   the clock value after that item, the point state, a display-update flag
//   and the entry flag.
//   The clock state and the result register both load at the edge that
//   accepts the item; the result is valid the cycle after.
//   Throughput: one item per cycle. in_stall is high only while a result is
//   held and the receiver stalls; a result taken in the same cycle frees the
//   register for the next transfer at once.
//   The user must write ticks_per_second (cfg_wr_en / cfg_wr_data) only
//   while idle; the block does not enforce it. Reset (rst, synchronous):
//   time 00:00:00, point off, no entry under way, ticks_per_second = 1000,
//   output register empty. While out_stall is high a held result stays put
//   and no input is taken; an empty result register still takes one transfer.
`default_nettype none

`include "clock_with_keypad_time_entry_defines.svh"

module clock_with_keypad_time_entry
  import clkkey_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,

  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,

  // item input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [7:0]  key_code,

  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       hours_shown,
  output logic [6:0]       minutes_shown,
  output logic [5:0]       seconds_now,
  output logic             point_on,
  output logic             display_update,
  output logic             entry_active
);

  // Architectural state
  logic [15:0] ticks_per_second;
  logic [6:0]  hour_count;
  logic [6:0]  minute_count;
  logic [5:0]  second_count;
  logic [15:0] subsecond_ticks;
  logic [1:0]  digits_entered;
  logic        point_state;

  logic [6:0]  hour_count_next;
  logic [6:0]  minute_count_next;
  logic [5:0]  second_count_next;
  logic [15:0] subsecond_ticks_next;
  logic [1:0]  digits_entered_next;
  logic        point_state_next;
  logic        display_update_next;

  logic        in_xfer;
  logic [16:0] sub_inc;
  logic        sec_done;
  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic        key_is_digit;
  logic [3:0]  digit;
  logic [6:0]  hour_entered;
  logic [6:0]  minute_entered;

  // Output register can take a new result when empty or being drained.
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  // Tick path: 17-bit increment so a counter at the top never wraps early.
  assign sub_inc  = {1'b0, subsecond_ticks} + 17'd1;
  assign sec_done = (sub_inc >= {1'b0, ticks_per_second});
  assign sec_inc  = {1'b0, second_count} + 7'd1;
  assign min_inc  = minute_count + 7'd1;

  assign key_is_digit = (key_code >= KEY_ZERO) && (key_code <= KEY_NINE);
  assign digit        = 4'(key_code - KEY_ZERO);

  // Units positions: the tens step just before left the units at zero,
  // so adding the digit completes the field.
  assign hour_entered   = hour_count + {3'd0, digit};
  assign minute_entered = minute_count + {3'd0, digit};

  always_comb begin
    hour_count_next      = hour_count;
    minute_count_next    = minute_count;
    second_count_next    = second_count;
    subsecond_ticks_next = subsecond_ticks;
    digits_entered_next  = digits_entered;
    point_state_next     = point_state;
    display_update_next  = 1'b0;

    if (opcode == OP_TICK) begin
      // ticks are ignored while an entry is under way
      if (digits_entered == POS_HOUR_TENS) begin
        // half-second toggle, then full-second toggle; both can fire at once
        if (subsecond_ticks == {1'b0, ticks_per_second[15:1]}) begin
          point_state_next = ~point_state;
        end
        subsecond_ticks_next = sub_inc[15:0];
        if (sec_done) begin
          subsecond_ticks_next = '0;
          point_state_next     = (subsecond_ticks == {1'b0, ticks_per_second[15:1]})
                                 ? point_state : ~point_state;
          display_update_next  = 1'b1;
          if (sec_inc >= SECONDS_WRAP) begin
            second_count_next = '0;
            if (min_inc >= MINUTES_WRAP) begin
              minute_count_next = '0;
              hour_count_next   = (hour_count >= HOURS_LAST) ? 7'd0 : hour_count + 7'd1;
            end else begin
              minute_count_next = min_inc;
            end
          end else begin
            second_count_next = sec_inc[5:0];
          end
        end
      end
    end else if (key_code == KEY_STAR) begin
      digits_entered_next = POS_HOUR_TENS;
    end else if (key_is_digit) begin
      display_update_next = 1'b1;
      digits_entered_next = digits_entered + 2'd1;
      case (digits_entered)
        POS_HOUR_TENS: begin
          minute_count_next = '0;
          hour_count_next   = times_ten(digit);
        end
        POS_HOUR_UNITS: begin
          hour_count_next = hour_entered;
        end
        POS_MIN_TENS: begin
          minute_count_next = times_ten(digit);
        end
        POS_MIN_UNITS: begin
          // entry complete: clamp out-of-range fields, restart the minute
          hour_count_next   = (hour_count >= HOURS_WRAP) ? 7'd0 : hour_count;
          minute_count_next = (minute_entered >= MINUTES_WRAP) ? 7'd0 : minute_entered;
          second_count_next = '0;
        end
        default: begin
          hour_count_next = hour_count;
        end
      endcase
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TICKS_PER_SECOND_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  // Clock state, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count      <= '0;
      minute_count    <= '0;
      second_count    <= '0;
      subsecond_ticks <= '0;
      digits_entered  <= POS_HOUR_TENS;
      point_state     <= 1'b0;
    end else if (in_xfer) begin
      hour_count      <= hour_count_next;
      minute_count    <= minute_count_next;
      second_count    <= second_count_next;
      subsecond_ticks <= subsecond_ticks_next;
      digits_entered  <= digits_entered_next;
      point_state     <= point_state_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload, held while stalled
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      hours_shown    <= hour_count_next;
      minutes_shown  <= minute_count_next;
      seconds_now    <= second_count_next;
      point_on       <= point_state_next;
      display_update <= display_update_next;
      entry_active   <= (digits_entered_next != POS_HOUR_TENS);
    end
  end

  // Every accepted item yields a result in the next cycle.
  `CLKKEY_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid,
                      "accepted item produced no result")

  // A tick taken during entry changes nothing and requests no refresh.
  `CLKKEY_ASSERT_NEXT(a_tick_ignored_in_entry,
                      in_xfer && (opcode == OP_TICK) && (digits_entered != POS_HOUR_TENS),
                      out_valid && !display_update && entry_active &&
                      $stable(subsecond_ticks),
                      "tick during entry was not ignored")

  // Seconds never leave their range.
  `CLKKEY_ASSERT_NOW(a_seconds_range, out_valid, seconds_now < 6'd60,
                     "seconds out of range")

endmodule

`default_nettype wire

/* bench/clock_with_keypad_time_entry_tb.sv */
// Self-checking bench for the keypad clock: random stalls, entry sequences and tick bursts.
`default_nettype none

module clock_with_keypad_time_entry_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import clkkey_pkg::*;

  // Cycles with no transfer on either side before the run is declared hung.
  // Longest correct quiet stretch is a sender gap plus a receiver stall plus
  // the short settle before a register write.
  localparam int QUIET_LIMIT = 2000;

  // One display snapshot, in the order of the result ports.
  typedef struct packed {
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic       point;
    logic       update;
    logic       entry;
  } display_t;

  // One input item: tick or key press.
  typedef struct packed {
    logic       op;
    logic [7:0] key;
  } press_t;

  // Shadow clock: tracks time, blink point and entry position, and holds the
  // displays the block owes us, oldest first.
  class clock_shadow;
    int unsigned rate;
    int unsigned hrs, mins, secs, sub;
    bit [1:0]    slot;
    bit          point;
    display_t    shown_q[$];
    int unsigned faults;

    function new();
      rate   = TICKS_PER_SECOND_RESET;
      hrs    = 0;
      mins   = 0;
      secs   = 0;
      sub    = 0;
      slot   = POS_HOUR_TENS;
      point  = 1'b0;
      faults = 0;
    endfunction

    // One timer tick outside entry; returns 1 when a full second elapsed.
    function bit count_tick();
      if (sub == (rate >> 1)) point = ~point;
      sub = (sub + 1) & 'h1FFFF;
      if (sub < rate) return 1'b0;
      sub   = 0;
      point = ~point;
      secs++;
      if (secs >= SECONDS_WRAP) begin
        secs = 0;
        mins++;
        if (mins >= MINUTES_WRAP) begin
          mins = 0;
          hrs  = (hrs >= HOURS_LAST) ? 0 : hrs + 1;
        end
      end
      return 1'b1;
    endfunction

    function void enter_digit(int unsigned d);
      case (slot)
        POS_HOUR_TENS: begin
          mins = 0;
          hrs  = d * 10;
        end
        POS_HOUR_UNITS: hrs = hrs - hrs % 10 + d;
        POS_MIN_TENS:   mins = d * 10;
        default: begin
          // last digit: clamp out-of-range fields and restart the seconds
          mins = mins - mins % 10 + d;
          if (hrs >= HOURS_WRAP) hrs = 0;
          secs = 0;
          if (mins >= MINUTES_WRAP) mins = 0;
        end
      endcase
      slot = slot + 2'd1;
    endfunction

    // Called on every accepted input transfer.
    function void take_item(logic op, logic [7:0] key);
      display_t d;
      bit upd;
      upd = 1'b0;
      if (op == OP_TICK) begin
        if (slot == POS_HOUR_TENS) upd = count_tick();
      end else if (key == KEY_STAR) begin
        slot = POS_HOUR_TENS;
      end else if (key >= KEY_ZERO && key <= KEY_NINE) begin
        enter_digit(int'(key - KEY_ZERO));
        upd = 1'b1;
      end
      d.hours   = 7'(hrs);
      d.minutes = 7'(mins);
      d.seconds = 6'(secs);
      d.point   = point;
      d.update  = upd;
      d.entry   = (slot != POS_HOUR_TENS);
      shown_q.push_back(d);
    endfunction

    // Called on every accepted output transfer.
    function void match_display(display_t got);
      display_t want;
      if (shown_q.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected display %0d:%0d:%0d point=%0b update=%0b entry=%0b",
                   got.hours, got.minutes, got.seconds, got.point, got.update, got.entry);
        return;
      end
      want = shown_q.pop_front();
      if (got.hours !== want.hours || got.minutes !== want.minutes ||
          got.seconds !== want.seconds || got.point !== want.point ||
          got.update !== want.update || got.entry !== want.entry) begin
        faults++;
        if (faults <= 10)
          $display({"display mismatch: expected %0d:%0d:%0d point=%0b update=%0b entry=%0b,",
                    " got %0d:%0d:%0d point=%0b update=%0b entry=%0b"},
                   want.hours, want.minutes, want.seconds, want.point, want.update, want.entry,
                   got.hours, got.minutes, got.seconds, got.point, got.update, got.entry);
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        opcode      = OP_TICK;
  logic [7:0]  key_code    = '0;
  logic        out_stall   = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [6:0]  hours_shown;
  logic [6:0]  minutes_shown;
  logic [5:0]  seconds_now;
  logic        point_on;
  logic        display_update;
  logic        entry_active;

  clock_shadow shadow;
  press_t      items_q[$];     // items still to be sent in this phase
  int          in_calm  = 0;   // sender: items left in a no-gap stretch
  int          out_calm = 0;   // receiver: results left in a no-stall stretch
  int          out_hold = 0;   // receiver: stall cycles left for the current result
  int          quiet_cycles = 0;

  clock_with_keypad_time_entry u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .key_code       (key_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hours_shown    (hours_shown),
    .minutes_shown  (minutes_shown),
    .seconds_now    (seconds_now),
    .point_on       (point_on),
    .display_update (display_update),
    .entry_active   (entry_active)
  );

  always #5 clk = ~clk;

  // Random per-item wait; now and then a stretch of back-to-back items.
  function automatic int draw_pause(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void push_item(logic op, logic [7:0] key);
    items_q.push_back('{op, key});
  endfunction

  // Ticks carry random key codes: the key field must not matter on a tick.
  function automatic void push_ticks(int n);
    repeat (n) push_item(OP_TICK, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void push_digit(int d);
    push_item(OP_KEY, KEY_ZERO + 8'(d));
  endfunction

  // Random phase. Mostly complete four-digit entries followed by tick bursts,
  // so the clock runs from freshly set times; some entries are set to 23:59
  // with a burst, capped at 250 ticks, that rolls the day over at low rates.
  // The rest is noise keys, cancelled partial entries and bare tick bursts.
  // Noise keys are not counted toward n.
  function automatic void queue_random(int n, int unsigned rate);
    int made, pick, burst, hh, mm, cut_at;
    int dg[4];
    bit wrap, broken;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        wrap = ($urandom_range(0, 4) == 0);
        hh   = wrap ? 23 : $urandom_range(0, 99);
        mm   = wrap ? 59 : $urandom_range(0, 99);
        dg   = '{hh / 10, hh % 10, mm / 10, mm % 10};
        broken = !wrap && ($urandom_range(0, 9) == 0);
        cut_at = $urandom_range(1, 3);
        if ($urandom_range(0, 1)) push_item(OP_KEY, KEY_STAR);
        for (int i = 0; i < 4; i++) begin
          if (broken && i == cut_at) begin
            push_item(OP_KEY, KEY_STAR);
            break;
          end
          push_digit(dg[i]);
          // a tick in the middle of an entry must be dropped
          if (i < 3 && $urandom_range(0, 9) == 0) push_ticks(1);
        end
        made += 5;
        if (wrap) burst = 60 * rate + $urandom_range(0, rate);
        else      burst = $urandom_range(1, 3 * rate);
        if (burst > 250) burst = 250;
        push_ticks(burst);
        made += burst;
      end else if (pick < 65) begin
        burst = $urandom_range(1, 40);
        push_ticks(burst);
        made += burst;
      end else if (pick < 85) begin
        push_item(OP_KEY, 8'($urandom_range(0, 255)));
      end else begin
        // lone digit, a dropped tick or two, then cancel
        push_digit($urandom_range(0, 9));
        push_ticks($urandom_range(1, 2));
        push_item(OP_KEY, KEY_STAR);
        made += 2;
      end
    end
  endfunction

  // Send every queued item; the shadow sees each one on its transfer edge.
  task automatic send_all();
    press_t it;
    int pause;
    while (items_q.size() > 0) begin
      it    = items_q.pop_front();
      pause = draw_pause(in_calm);
      if (pause > 0) begin
        in_valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      in_valid <= 1'b1;
      opcode   <= it.op;
      key_code <= it.key;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      shadow.take_item(it.op, it.key);
    end
    in_valid <= 1'b0;
  endtask

  // Wait until every expected display is received, then let the result register drain.
  task automatic settle();
    while (shadow.shown_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_rate(logic [15:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow.rate = v;
  endtask

  // Receiver: check each transfer, then stall the next result a random while.
  // The stall count only runs down while a result is actually waiting.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        shadow.match_display(display_t'({hours_shown, minutes_shown, seconds_now,
                                          point_on, display_update, entry_active}));
        out_hold = draw_pause(out_calm);
      end else if (out_valid && out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  // Watchdog on progress: any transfer on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else                                                      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("clock_with_keypad_time_entry verification failed");
      $finish;
    end
  end

  initial begin
    shadow = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset rate of 1000 ticks per second.
    push_item(OP_TICK, 8'h00);
    push_item(OP_KEY, 8'h00);        // key code extremes: ignored
    push_item(OP_KEY, 8'hFF);
    push_item(OP_KEY, KEY_ZERO - 8'd1);  // neighbors of the digit range
    push_item(OP_KEY, KEY_NINE + 8'd1);
    push_item(OP_KEY, KEY_STAR);     // cancel with no entry open
    push_digit(0);
    push_digit(7);
    push_item(OP_KEY, KEY_STAR);     // cancel after two digits, 07:00 stays
    push_digit(9);
    push_item(OP_TICK, 8'hFF);       // tick during entry is dropped
    push_digit(9);
    push_digit(9);
    push_digit(9);                   // 99:99 clamps to 00:00, seconds cleared
    push_digit(2);
    push_digit(3);
    push_digit(5);
    push_digit(9);                   // 23:59
    // run the counter past the half-second point toggle
    push_ticks(505);
    send_all();
    settle();

    // Lower the rate below the running counter: next tick ends the second.
    write_rate(16'd3);
    push_ticks(1);
    queue_random(250, 3);
    send_all();
    settle();

    // Smallest legal rate: a second every other tick, frequent rollovers.
    write_rate(16'd2);
    queue_random(300, 2);
    send_all();
    settle();

    // Largest rate: the counter never completes a second here.
    write_rate(16'hFFFF);
    queue_random(100, 16'hFFFF);
    send_all();
    settle();

    begin
      int unsigned r;
      r = $urandom_range(4, 9);
      write_rate(16'(r));
      queue_random(200, r);
      send_all();
      settle();
      r = $urandom_range(10, 40);
      write_rate(16'(r));
      queue_random(150, r);
      send_all();
      settle();
    end

    if (shadow.faults == 0 && shadow.shown_q.size() == 0) begin
      $display("clock_with_keypad_time_entry verification clean");
    end else begin
      $display("clock_with_keypad_time_entry verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
